// ===== src/gsbe_pkg.sv =====
// shared constants and types for the gyro stationary bias estimator
`default_nettype none

package gsbe_pkg;

  localparam int SAMPLES     = 128;
  localparam int IDX_W       = $clog2(SAMPLES);
  localparam int RATE_W      = 16;
  localparam int OUT_W       = RATE_W + 1;
  localparam int TICK_W      = 32;
  localparam int THR_W       = 32;
  localparam int SUM_W       = RATE_W + IDX_W;
  localparam int SQ_W        = 2 * RATE_W - 1 + IDX_W;
  localparam int PROD_W      = 2 * SUM_W;
  localparam int VAR_W       = (SQ_W > THR_W) ? SQ_W : THR_W;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'(2000);
  localparam logic [TICK_W-1:0] MIN_TICK        = TICK_W'(1);

  typedef logic signed [RATE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [SQ_W-1:0]          sqsum_t;

  typedef struct {
    sample_t rate [3];
    logic    tick_ok;
  } item_t;

  typedef struct {
    logic  valid;
    logic  full;
    item_t item;
  } window_t;

endpackage

`default_nettype wire

// ===== src/gsbe_front.sv =====
// input side: takes transfers, flags the tick and queues items for the back end
`default_nettype none

module gsbe_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire gsbe_pkg::sample_t rate_x,
  input  wire gsbe_pkg::sample_t rate_y,
  input  wire gsbe_pkg::sample_t rate_z,
  input  wire logic [31:0]       tick_now,
  input  wire logic              pop,
  output logic                   head_valid,
  output gsbe_pkg::item_t        head
);

  localparam int DEPTH = gsbe_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  gsbe_pkg::item_t queue [DEPTH];
  gsbe_pkg::item_t incoming;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;
  logic push;

  always_comb begin
    incoming.rate[0] = rate_x;
    incoming.rate[1] = rate_y;
    incoming.rate[2] = rate_z;
    incoming.tick_ok = tick_now > gsbe_pkg::MIN_TICK;
  end

  assign in_stall   = count == CNT_W'(DEPTH);
  assign push       = in_valid & ~in_stall;
  assign head_valid = count != '0;
  assign head       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
  end

endmodule

`default_nettype wire

// ===== src/gsbe_window.sv =====
// sample ring and running per-axis sums and sums of squares
`default_nettype none

module gsbe_window (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic              head_valid,
  input  wire gsbe_pkg::item_t   head,
  output logic                   pop,
  output gsbe_pkg::window_t      stage,
  output gsbe_pkg::sum_t         axis_sum [3],
  output gsbe_pkg::sqsum_t       axis_square_sum [3]
);

  localparam int SAMPLES = gsbe_pkg::SAMPLES;
  localparam int IDX_W   = gsbe_pkg::IDX_W;
  localparam int RATE_W  = gsbe_pkg::RATE_W;
  localparam int SUM_W   = gsbe_pkg::SUM_W;
  localparam int SQ_W    = gsbe_pkg::SQ_W;
  localparam int SQR_W   = 2 * RATE_W - 1;

  logic [3*RATE_W-1:0] ring [SAMPLES];
  logic [3*RATE_W-1:0] ring_rdata;
  logic [IDX_W-1:0]    write_index;
  logic                ring_full;
  logic                last_index;

  logic             s0_valid;
  logic             s0_old_ok;
  logic             s0_full;
  logic [IDX_W-1:0] s0_idx;
  gsbe_pkg::item_t  s0_item;

  logic                     s1_valid;
  logic                     s1_full;
  gsbe_pkg::item_t          s1_item;
  logic signed [RATE_W:0]   s1_diff [3];
  logic [SQR_W-1:0]         s1_new_sq [3];
  logic [SQR_W-1:0]         s1_old_sq [3];

  logic            s2_valid;
  logic            s2_full;
  gsbe_pkg::item_t s2_item;

  gsbe_pkg::sample_t        old_smp [3];
  logic signed [RATE_W:0]   diff [3];
  logic signed [2*RATE_W-1:0] new_prod [3];
  logic signed [2*RATE_W-1:0] old_prod [3];

  assign last_index = write_index == IDX_W'(SAMPLES - 1);
  assign pop        = advance & head_valid;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      // entries not yet written since reset read as zero
      old_smp[a]  = s0_old_ok ? gsbe_pkg::sample_t'(ring_rdata[a*RATE_W +: RATE_W]) : '0;
      diff[a]     = (RATE_W+1)'(s0_item.rate[a]) - (RATE_W+1)'(old_smp[a]);
      new_prod[a] = (2*RATE_W)'(s0_item.rate[a]) * (2*RATE_W)'(s0_item.rate[a]);
      old_prod[a] = (2*RATE_W)'(old_smp[a]) * (2*RATE_W)'(old_smp[a]);
    end
  end

  always_comb begin
    stage.valid = s2_valid;
    stage.full  = s2_full;
    stage.item  = s2_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      ring_full   <= 1'b0;
      s0_valid    <= 1'b0;
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        axis_sum[a]        <= '0;
        axis_square_sum[a] <= '0;
      end
    end else if (advance) begin
      s0_valid <= head_valid;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      if (head_valid) begin
        write_index <= last_index ? '0 : write_index + IDX_W'(1);
        if (last_index) begin
          ring_full <= 1'b1;
        end
      end
      if (s1_valid) begin
        for (int a = 0; a < 3; a++) begin
          axis_sum[a]        <= axis_sum[a] + SUM_W'(s1_diff[a]);
          axis_square_sum[a] <= axis_square_sum[a] + SQ_W'(s1_new_sq[a])
                                - SQ_W'(s1_old_sq[a]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_item   <= head;
      s0_idx    <= write_index;
      s0_old_ok <= ring_full;
      s0_full   <= ring_full | last_index;
      s1_item   <= s0_item;
      s1_full   <= s0_full;
      for (int a = 0; a < 3; a++) begin
        s1_diff[a]   <= diff[a];
        s1_new_sq[a] <= new_prod[a][SQR_W-1:0];
        s1_old_sq[a] <= old_prod[a][SQR_W-1:0];
      end
      s2_item <= s1_item;
      s2_full <= s1_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ring_rdata <= ring[write_index];
      if (s0_valid) begin
        ring[s0_idx] <= {s0_item.rate[2], s0_item.rate[1], s0_item.rate[0]};
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/gsbe_decide.sv =====
// variance check, bias latch, correction and output register
`default_nettype none

module gsbe_decide (
  input  wire logic               clk,
  input  wire logic               rst,
  output logic                    advance,
  input  wire gsbe_pkg::window_t  stage,
  input  wire gsbe_pkg::sum_t     axis_sum [3],
  input  wire gsbe_pkg::sqsum_t   axis_square_sum [3],
  input  wire logic               config_write,
  input  wire logic [31:0]        config_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [16:0]      corrected_x,
  output logic signed [16:0]      corrected_y,
  output logic signed [16:0]      corrected_z,
  output logic                    calibrated,
  output logic                    calibrated_now
);

  localparam int SAMPLES = gsbe_pkg::SAMPLES;
  localparam int IDX_W   = gsbe_pkg::IDX_W;
  localparam int RATE_W  = gsbe_pkg::RATE_W;
  localparam int OUT_W   = gsbe_pkg::OUT_W;
  localparam int SUM_W   = gsbe_pkg::SUM_W;
  localparam int PROD_W  = gsbe_pkg::PROD_W;
  localparam int VAR_W   = gsbe_pkg::VAR_W;

  logic [gsbe_pkg::THR_W-1:0] variance_threshold;
  logic                       bias_found;
  gsbe_pkg::sample_t          bias_value [3];

  logic              s3_valid;
  logic              s3_full;
  gsbe_pkg::item_t   s3_item;
  gsbe_pkg::sum_t    s3_sum [3];
  gsbe_pkg::sqsum_t  s3_sq [3];
  logic [PROD_W-1:0] s3_prod [3];

  logic [SUM_W-1:0]         mag [3];
  logic [PROD_W-1:0]        sq_mean [3];
  logic [VAR_W-1:0]         variance [3];
  logic [2:0]               quiet;
  logic signed [SUM_W:0]    rounded [3];
  logic signed [SUM_W:0]    mean_full [3];
  gsbe_pkg::sample_t        mean [3];
  gsbe_pkg::sample_t        bias_use [3];
  logic signed [OUT_W-1:0]  corr [3];
  logic                     latch;

  assign advance = ~out_valid | ~out_stall;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag[a] = axis_sum[a][SUM_W-1] ? SUM_W'(-axis_sum[a]) : SUM_W'(axis_sum[a]);
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sq_mean[a]  = s3_prod[a] >> IDX_W;
      variance[a] = VAR_W'(s3_sq[a]) - VAR_W'(sq_mean[a]);
      quiet[a]    = variance[a] < VAR_W'(variance_threshold);
      // mean truncated toward zero
      rounded[a]   = (SUM_W+1)'(s3_sum[a])
                     + (s3_sum[a][SUM_W-1] ? (SUM_W+1)'(SAMPLES - 1) : '0);
      mean_full[a] = rounded[a] >>> IDX_W;
      mean[a]      = gsbe_pkg::sample_t'(mean_full[a][RATE_W-1:0]);
    end
    latch = s3_valid & ~bias_found & s3_full & (&quiet) & s3_item.tick_ok;
    for (int a = 0; a < 3; a++) begin
      bias_use[a] = latch ? mean[a] : bias_value[a];
      corr[a]     = OUT_W'(s3_item.rate[a]) - OUT_W'(bias_use[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      variance_threshold <= gsbe_pkg::THRESHOLD_RESET;
      bias_found         <= 1'b0;
      s3_valid           <= 1'b0;
      out_valid          <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        bias_value[a] <= '0;
      end
    end else begin
      if (config_write) begin
        variance_threshold <= config_data;
      end
      if (advance) begin
        s3_valid  <= stage.valid;
        out_valid <= s3_valid;
        if (latch) begin
          bias_found <= 1'b1;
          for (int a = 0; a < 3; a++) begin
            bias_value[a] <= mean[a];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_item <= stage.item;
      s3_full <= stage.full;
      for (int a = 0; a < 3; a++) begin
        s3_sum[a]  <= axis_sum[a];
        s3_sq[a]   <= axis_square_sum[a];
        s3_prod[a] <= PROD_W'(mag[a]) * PROD_W'(mag[a]);
      end
      corrected_x    <= corr[0];
      corrected_y    <= corr[1];
      corrected_z    <= corr[2];
      calibrated     <= bias_found | latch;
      calibrated_now <= latch;
    end
  end

endmodule

`default_nettype wire

// ===== src/gyro_stationary_bias_estimator.sv =====
// top level of the gyro stationary bias estimator
// path from input transfer to output: input queue, window stages s0, s1 and s2, decide stage s3, output register
// throughput: one item per cycle while out_stall is low; a two-entry input queue and the
// output register let either side stall independently
// reset: sums, ring fill state and bias cleared, threshold back to 2000; ring
// entries are tracked by fill position so no clearing pass is needed
`default_nettype none

module gyro_stationary_bias_estimator (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] rate_x,
  input  wire logic signed [15:0] rate_y,
  input  wire logic signed [15:0] rate_z,
  input  wire logic [31:0]        tick_now,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [16:0]      corrected_x,
  output logic signed [16:0]      corrected_y,
  output logic signed [16:0]      corrected_z,
  output logic                    calibrated,
  output logic                    calibrated_now,
  input  wire logic               config_write,
  input  wire logic [31:0]        config_data
);

  logic                      advance;
  logic                      pop;
  logic                      head_valid;
  gsbe_pkg::item_t           head;
  gsbe_pkg::window_t         stage;
  gsbe_pkg::sum_t            axis_sum [3];
  gsbe_pkg::sqsum_t          axis_square_sum [3];

  gsbe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rate_x     (rate_x),
    .rate_y     (rate_y),
    .rate_z     (rate_z),
    .tick_now   (tick_now),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  gsbe_window u_window (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop),
    .stage           (stage),
    .axis_sum        (axis_sum),
    .axis_square_sum (axis_square_sum)
  );

  gsbe_decide u_decide (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .stage           (stage),
    .axis_sum        (axis_sum),
    .axis_square_sum (axis_square_sum),
    .config_write    (config_write),
    .config_data     (config_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .corrected_x     (corrected_x),
    .corrected_y     (corrected_y),
    .corrected_z     (corrected_z),
    .calibrated      (calibrated),
    .calibrated_now  (calibrated_now)
  );

  // the latching item always reports itself as calibrated
  assert property (@(posedge clk) disable iff (rst)
    out_valid && calibrated_now |-> calibrated)
    else $error("calibrated_now without calibrated");

  // the bias latches at most once per reset
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && calibrated_now |=> !out_valid || !calibrated_now)
    else $error("bias latched twice");

  // once calibrated, later results stay calibrated
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && calibrated |=> !out_valid || calibrated)
    else $error("calibration lost");

endmodule

`default_nettype wire
